FILE: rtl/cbop_pkg.sv
// shared types and constants for the capped bucket owner partitioner
package cbop_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_CAP,
        ST_DIV,
        ST_LOOK,
        ST_REBAL,
        ST_OUT
    } t_state;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DEFERRED = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    localparam logic [1:0] REG_PARTS  = 2'd0;
    localparam logic [1:0] REG_CHILD  = 2'd1;
    localparam logic [1:0] REG_BUCKET = 2'd2;

    localparam int CAP_NUM = 12;
    localparam int CAP_DEN = 10;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input item
        logic place;      // run the placement step
        logic div_start;  // start the offset or cap divide
        logic look;       // read owner table for bucket
        logic look_done;  // take registered owner read
        logic rebal_step; // one scan step of rebalancing
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic kind;
        logic div_done;
        logic rebal_go;   // the placement to run now is for the last child
        logic rebal_done;
        logic cap_need;   // first child, cap still to be divided out
    } t_stat;

endpackage

FILE: rtl/cbop_ctrl.sv
// controller state machine of the partitioner
module cbop_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    input  cbop_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output cbop_pkg::t_cmd  o_cmd
);

    cbop_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbop_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            cbop_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = cbop_pkg::ST_PLACE;
                end
            end
            cbop_pkg::ST_PLACE: begin
                if (i_stat.kind) begin
                    o_cmd.div_start = 1'b1;
                    n_state = cbop_pkg::ST_DIV;
                end else if (i_stat.cap_need) begin
                    o_cmd.div_start = 1'b1;
                    n_state = cbop_pkg::ST_CAP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state = i_stat.rebal_go ? cbop_pkg::ST_REBAL : cbop_pkg::ST_OUT;
                end
            end
            cbop_pkg::ST_CAP: begin
                if (i_stat.div_done) begin
                    o_cmd.place = 1'b1;
                    n_state = i_stat.rebal_go ? cbop_pkg::ST_REBAL : cbop_pkg::ST_OUT;
                end
            end
            cbop_pkg::ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.look = 1'b1;
                    n_state = cbop_pkg::ST_LOOK;
                end
            end
            cbop_pkg::ST_LOOK: begin
                o_cmd.look_done = 1'b1;
                n_state = cbop_pkg::ST_OUT;
            end
            cbop_pkg::ST_REBAL: begin
                if (i_stat.rebal_done) begin
                    n_state = cbop_pkg::ST_OUT;
                end else begin
                    o_cmd.rebal_step = 1'b1;
                end
            end
            cbop_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = cbop_pkg::ST_IDLE;
                end
            end
            default: n_state = cbop_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/cbop_div.sv
// restoring serial divider, one quotient bit per cycle
module cbop_div #(
    parameter int W = 48
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quot, n_quot;
    logic [W:0]    r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [W:0]    w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
    end

    always_comb begin
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        w_trial = {r_rem[W-1:0], r_quot[W-1]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem  = w_trial - {1'b0, i_den};
                n_quot = {r_quot[W-2:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_quot;

endmodule

FILE: rtl/cbop_dp.sv
// datapath: owner table, load counters, deferred list and lookup
module cbop_dp #(
    parameter int FANOUT      = 256,
    parameter int MAX_PARTS   = 16,
    parameter int OFFSET_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cbop_pkg::t_cmd         i_cmd,
    output cbop_pkg::t_stat        o_stat,
    input  logic [4:0]             i_parts_reg,
    input  logic [8:0]             i_child_reg,
    input  logic [47:0]            i_bucket_reg,
    input  logic                   i_kind,
    input  logic [3:0]             i_home,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic                   i_batch_end,
    output logic [3:0]             o_owner,
    output logic [1:0]             o_status,
    output logic                   o_batch_end
);

    localparam int FB = $clog2(FANOUT);
    localparam int CB = $clog2(FANOUT + 1);
    localparam int PB = (MAX_PARTS > 2) ? $clog2(MAX_PARTS) : 1;
    localparam int LB = CB;
    localparam int QW = (OFFSET_BITS > 48) ? OFFSET_BITS : 48;

    logic [3:0]  r_owner_mem [FANOUT];
    logic [FB-1:0] r_def_mem [FANOUT];
    logic [LB-1:0] r_load [MAX_PARTS];
    logic [CB-1:0] r_def_total, r_seen, r_cap, r_def_idx;
    logic [PB-1:0] r_scan, r_needy;
    logic          r_scan_on;
    logic          r_kind, r_batch;
    logic [3:0]    r_home, r_owner, r_rd;
    logic [1:0]    r_status;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [FB-1:0] r_def_rd;

    logic [8:0]    w_p, w_n;
    logic [CB-1:0] w_n_c;
    logic [12:0]   w_cap_num;
    logic [8:0]    w_cap_den;
    logic [15:0]   w_cap;
    logic          w_div_done;
    logic [QW-1:0] w_quot;
    logic [QW-1:0] w_num, w_den;
    logic          w_home_ok;
    logic [PB-1:0] w_home_i;

    // saturated register values
    always_comb begin
        w_p = {4'd0, i_parts_reg};
        if (w_p < 9'd1) w_p = 9'd1;
        if (w_p > 9'(MAX_PARTS)) w_p = 9'(MAX_PARTS);
        w_n = i_child_reg;
        if (int'(w_n) > FANOUT) w_n = 9'(FANOUT);
    end
    assign w_n_c = CB'(w_n);

    // cap operands, divided by the shared divider on the first child
    assign w_cap_num = 13'(w_n) * 13'(cbop_pkg::CAP_NUM);
    assign w_cap_den = w_p * 9'(cbop_pkg::CAP_DEN);
    assign w_cap     = w_quot[15:0] + 16'd1;

    assign w_home_ok = {5'd0, r_home} < w_p;
    assign w_home_i  = PB'(r_home);
    assign w_num = r_kind ? QW'(r_offset) : QW'(w_cap_num);
    assign w_den = r_kind ? QW'(i_bucket_reg) : QW'(w_cap_den);

    cbop_div #(.W(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) r_rd <= r_owner_mem[FB'(w_quot)];
        r_def_rd <= r_def_mem[FB'(r_def_idx)];
        if (i_cmd.place && r_seen < w_n_c) begin
            if (w_home_ok && CB'(r_load[w_home_i]) < ((r_seen == '0) ? CB'(w_cap) : r_cap)) begin
                r_owner_mem[FB'(r_seen)] <= r_home;
            end else begin
                r_def_mem[FB'(r_def_total)] <= FB'(r_seen);
            end
        end
        if (i_cmd.rebal_step && r_scan_on && r_scan == PB'(w_p - 9'd1)) begin
            r_owner_mem[r_def_rd] <= 4'(r_needy);
        end
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_total <= '0;
            r_seen      <= '0;
            r_cap       <= '0;
            r_def_idx   <= '0;
            r_scan_on   <= 1'b0;
            for (int k = 0; k < MAX_PARTS; k++) r_load[k] <= '0;
        end else begin
            if (i_cmd.place && r_seen < w_n_c) begin
                if (r_seen == '0) r_cap <= CB'(w_cap);
                if (w_home_ok && CB'(r_load[w_home_i]) < ((r_seen == '0) ? CB'(w_cap) : r_cap)) begin
                    r_load[w_home_i] <= r_load[w_home_i] + 1'b1;
                end else begin
                    r_def_total <= r_def_total + 1'b1;
                end
                r_seen <= r_seen + 1'b1;
                if (r_seen + 1'b1 == w_n_c) begin
                    r_def_idx  <= '0;
                    r_scan_on  <= 1'b0;
                end
            end
            // rebalance: a first step fetches the deferred child, then scan partitions
            if (i_cmd.rebal_step) begin
                if (!r_scan_on) begin
                    r_scan_on <= 1'b1;
                    r_scan    <= '0;
                    r_needy   <= '0;
                end else if (r_scan == PB'(w_p - 9'd1)) begin
                    r_load[r_needy] <= r_load[r_needy] + 1'b1;
                    r_def_idx <= r_def_idx + 1'b1;
                    r_scan_on <= 1'b0;
                end else begin
                    if (r_load[r_scan + 1'b1] < r_load[r_needy]) r_needy <= r_scan + 1'b1;
                    r_scan <= r_scan + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_home   <= i_home;
            r_offset <= i_offset;
            r_batch  <= i_batch_end;
        end
        if (i_cmd.place) begin
            r_owner  <= 4'd0;
            if (r_seen >= w_n_c) begin
                r_status <= cbop_pkg::STATUS_RANGE;
            end else if (!w_home_ok) begin
                r_status <= cbop_pkg::STATUS_RANGE;
            end else if (CB'(r_load[w_home_i]) >= ((r_seen == '0) ? CB'(w_cap) : r_cap)) begin
                r_status <= cbop_pkg::STATUS_DEFERRED;
            end else begin
                r_status <= cbop_pkg::STATUS_OK;
                r_owner  <= r_home;
            end
        end
        if (i_cmd.look_done) begin
            if (i_bucket_reg == '0 || w_quot >= QW'(w_n)) begin
                r_status <= cbop_pkg::STATUS_RANGE;
                r_owner  <= 4'd0;
            end else begin
                r_status <= cbop_pkg::STATUS_OK;
                r_owner  <= r_rd;
            end
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.rebal_go   = (r_seen < w_n_c) && (r_seen + 1'b1 == w_n_c);
    assign o_stat.rebal_done = !r_scan_on && (r_def_idx >= r_def_total);
    assign o_stat.cap_need   = !r_kind && (r_seen == '0) && (w_n_c != '0);
    assign o_owner     = r_owner;
    assign o_status    = r_status;
    assign o_batch_end = r_batch;

endmodule

FILE: rtl/capped_bucket_owner_partitioner.sv
// top level of the capped bucket owner partitioner
//
// channel | dir | fields
// s_axis  | in  | tdata: home_partition[3:0], offset[51:4], zero fill; tuser: kind; tlast: batch_end
// m_axis  | out | tdata: owner[3:0], status[5:4], zero fill; tlast: batch_end_out
// cfg     | in  | i_cfg_we, i_cfg_index, i_cfg_data (48 bits)
//
// one request at a time; a placement passes the place and output states before the next accept
// the first placement also divides out the cap on the shared divider before it places
// a lookup divides the offset by the bucket size on the one-bit-a-cycle divider
// the last placement adds a rebalance: per deferred child, a fetch step and a scan of the load
// counters over the saturated partition count
// synchronous active-low reset clears counters and loads; the user must write tables before use,
// not enforced by the block; a stalled result holds in the output register until m_axis_tready
module capped_bucket_owner_partitioner #(
    parameter int FANOUT      = 256,
    parameter int MAX_PARTS   = 16,
    parameter int OFFSET_BITS = 48,
    localparam int IN_W       = ((OFFSET_BITS + 4 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_W-1:0]        s_axis_tdata,  // home_partition, offset, zero fill
    input  logic                   s_axis_tuser,  // kind
    input  logic                   s_axis_tlast,  // batch_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,  // owner, status, zero fill
    output logic                   m_axis_tlast,  // batch_end_out
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [47:0]            i_cfg_data
);

    logic [4:0]  r_parts;
    logic [8:0]  r_child;
    logic [47:0] r_bucket;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts  <= 5'd2;
            r_child  <= 9'd256;
            r_bucket <= 48'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbop_pkg::REG_PARTS:  r_parts  <= i_cfg_data[4:0];
                cbop_pkg::REG_CHILD:  r_child  <= i_cfg_data[8:0];
                cbop_pkg::REG_BUCKET: r_bucket <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cbop_pkg::t_cmd  w_cmd;
    cbop_pkg::t_stat w_stat;
    logic [3:0] w_owner;
    logic [1:0] w_status;

    cbop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    cbop_dp #(
        .FANOUT      (FANOUT),
        .MAX_PARTS   (MAX_PARTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_parts_reg  (r_parts),
        .i_child_reg  (r_child),
        .i_bucket_reg (r_bucket),
        .i_kind       (s_axis_tuser),
        .i_home       (s_axis_tdata[3:0]),
        .i_offset     (s_axis_tdata[OFFSET_BITS+3:4]),
        .i_batch_end  (s_axis_tlast),
        .o_owner      (w_owner),
        .o_status     (w_status),
        .o_batch_end  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_status, w_owner};

endmodule

FILE: tb/sv/tb_capped_bucket_owner_partitioner.sv
// testbench for the capped bucket owner partitioner: placement then offset lookups
module tb_capped_bucket_owner_partitioner;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FANOUT      = 256;
    localparam int MAX_PARTS   = 16;
    localparam int OFFSET_BITS = 48;
    localparam int IN_W        = ((OFFSET_BITS + 4 + 7) / 8) * 8;

    // request kinds carried in tuser
    localparam logic KIND_PLACE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // settle time after the last result, for a placement phase with rebalance and for lookups
    localparam int REBAL_SETTLE = (MAX_PARTS + 2) * FANOUT;
    localparam int LOOK_SETTLE  = OFFSET_BITS + 16;

    localparam logic [47:0] OFF_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [3:0] owner;
        logic [1:0] status;
        logic       last;
    } t_owner_res;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;   // home_partition[3:0], offset[51:4], zero fill
    logic                   s_axis_tuser;   // kind
    logic                   s_axis_tlast;   // batch_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // owner[3:0], status[5:4], zero fill
    logic                   m_axis_tlast;   // batch_end_out
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_index;
    logic [47:0]            i_cfg_data;

    capped_bucket_owner_partitioner #(
        .FANOUT      (FANOUT),
        .MAX_PARTS   (MAX_PARTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow copy of the block's registers and tables
    logic [4:0]  parts_reg;
    logic [8:0]  children_reg;
    logic [47:0] bucket_reg;
    logic [3:0]  owner_tbl [FANOUT];
    int          part_load [MAX_PARTS];
    int          deferred_child [FANOUT];
    int          deferred_cnt;
    int          placed_cnt;
    int          cap_latched;

    t_owner_res  owner_q[$];
    int          err_count;
    int          req_count;
    int          res_count;
    int          deferred_seen;
    int          range_seen;
    bit          calm;   // no idling on either side while set

    // predicted result of one accepted request; placement updates the tables
    task automatic compute_owner(input logic kind, input logic [3:0] home,
                                 input logic [47:0] off, input logic last,
                                 output t_owner_res r);
        int n;
        int p;
        int needy;
        logic [47:0] bucket;
        n = (children_reg > FANOUT) ? FANOUT : children_reg;
        p = (parts_reg < 1) ? 1 : ((parts_reg > MAX_PARTS) ? MAX_PARTS : parts_reg);
        r.owner  = 4'd0;
        r.status = cbop_pkg::STATUS_OK;
        r.last   = last;
        if (kind == KIND_PLACE) begin
            if (placed_cnt >= n) begin
                // phase already closed
                r.status = cbop_pkg::STATUS_RANGE;
            end else begin
                if (placed_cnt == 0)
                    cap_latched = (n * cbop_pkg::CAP_NUM) / (p * cbop_pkg::CAP_DEN) + 1;
                if (home >= p) begin
                    deferred_child[deferred_cnt++] = placed_cnt;
                    r.status = cbop_pkg::STATUS_RANGE;
                end else if (part_load[home] >= cap_latched) begin
                    deferred_child[deferred_cnt++] = placed_cnt;
                    r.status = cbop_pkg::STATUS_DEFERRED;
                end else begin
                    part_load[home]++;
                    owner_tbl[placed_cnt] = home;
                    r.owner = home;
                end
                placed_cnt++;
                if (placed_cnt == n) begin
                    // spread deferred children over the first least-loaded partitions
                    for (int i = 0; i < deferred_cnt; i++) begin
                        needy = 0;
                        for (int q = 1; q < p; q++)
                            if (part_load[q] < part_load[needy]) needy = q;
                        part_load[needy]++;
                        owner_tbl[deferred_child[i]] = needy[3:0];
                    end
                end
            end
        end else begin
            if (bucket_reg == 48'd0) begin
                r.status = cbop_pkg::STATUS_RANGE;
            end else begin
                bucket = off / bucket_reg;
                if (bucket >= n) r.status = cbop_pkg::STATUS_RANGE;
                else r.owner = owner_tbl[bucket[7:0]];
            end
        end
    endtask

    // one request; the caller stands at a rising edge
    task automatic send_req(input logic kind, input logic [3:0] home,
                            input logic [47:0] off, input logic last);
        t_owner_res r;
        if (!calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({off, home});
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        compute_owner(kind, home, off, last, r);
        owner_q.insert(owner_q.size(), r);
        req_count++;
    endtask

    // sender holds off until every result is back, then lets the block settle
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        while (owner_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            cbop_pkg::REG_PARTS:  parts_reg    = val[4:0];
            cbop_pkg::REG_CHILD:  children_reg = val[8:0];
            cbop_pkg::REG_BUCKET: bucket_reg   = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_off();
        return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
    endfunction

    // a run of children under one partition count, homes skewed towards one partition
    task automatic test_place_segment(input int cnt, input logic [4:0] parts,
                                      input logic [3:0] fav);
        logic [3:0] home;
        drain(LOOK_SETTLE);
        write_reg(cbop_pkg::REG_PARTS, {43'd0, parts});
        for (int i = 0; i < cnt; i++) begin
            home = ($urandom_range(99) < 55) ? fav : 4'($urandom_range(15));
            send_req(KIND_PLACE, home, rand_off(), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_placement();
        drain(LOOK_SETTLE);
        // above the fanout, so every child slot gets an owner
        write_reg(cbop_pkg::REG_CHILD, 48'd300);
        write_reg(cbop_pkg::REG_PARTS, 48'd16);
        // first child latches a tight cap; edge homes first
        send_req(KIND_PLACE, 4'd0, 48'd0, 1'b0);
        send_req(KIND_PLACE, 4'd15, OFF_MAX, 1'b1);
        test_place_segment(50, 5'd16, 4'd3);
        test_place_segment(51, 5'd0, 4'd0);    // saturates to one partition
        test_place_segment(51, 5'd31, 4'd7);   // saturates to the maximum
        test_place_segment(51, 5'd1, 4'd0);
        test_place_segment(51, 5'd5, 4'd2);    // last child, rebalance over five
        drain(REBAL_SETTLE);
    endtask

    task automatic test_directed_lookups();
        write_reg(cbop_pkg::REG_CHILD, 48'd256);
        write_reg(cbop_pkg::REG_BUCKET, 48'd1);
        send_req(KIND_LOOKUP, 4'd0, 48'd0, 1'b0);
        send_req(KIND_LOOKUP, 4'd15, 48'd255, 1'b1);
        send_req(KIND_LOOKUP, 4'd0, 48'd256, 1'b0);
        send_req(KIND_LOOKUP, 4'd0, OFF_MAX, 1'b1);
        // placement after the phase closed
        send_req(KIND_PLACE, 4'd1, 48'd0, 1'b0);
        drain(LOOK_SETTLE);
        write_reg(cbop_pkg::REG_BUCKET, 48'd0);
        send_req(KIND_LOOKUP, 4'd0, 48'd5, 1'b1);
        drain(LOOK_SETTLE);
        write_reg(cbop_pkg::REG_BUCKET, OFF_MAX);
        send_req(KIND_LOOKUP, 4'd0, OFF_MAX, 1'b0);
        send_req(KIND_LOOKUP, 4'd0, OFF_MAX - 1, 1'b1);
        drain(LOOK_SETTLE);
        write_reg(cbop_pkg::REG_CHILD, 48'd0);
        send_req(KIND_LOOKUP, 4'd0, 48'd0, 1'b0);
        send_req(KIND_PLACE, 4'd0, 48'd0, 1'b1);
    endtask

    // mostly in-range lookups for one register setting, with some stray placements
    task automatic test_lookups(input int cnt, input logic [8:0] children,
                                input logic [47:0] bsize);
        int n;
        logic [63:0] off;
        drain(LOOK_SETTLE);
        write_reg(cbop_pkg::REG_CHILD, {39'd0, children});
        write_reg(cbop_pkg::REG_BUCKET, bsize);
        n = (children > FANOUT) ? FANOUT : children;
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(99) < 6) begin
                send_req(KIND_PLACE, 4'($urandom_range(15)), rand_off(), 1'($urandom_range(1)));
            end else begin
                if (n == 0 || bsize == 0 || $urandom_range(99) < 15) begin
                    off = {16'd0, rand_off()};
                end else begin
                    off = 64'($urandom_range(n - 1 + (($urandom_range(9) == 0) ? 4 : 0)))
                          * bsize;
                    if (bsize > 1) off += {$urandom(), $urandom()} % bsize;
                end
                send_req(KIND_LOOKUP, 4'($urandom_range(15)), off[47:0], 1'($urandom_range(1)));
            end
        end
    endtask

    // receiver stalls at random, and each result is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_owner_res e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                res_count++;
                if (owner_q.size() == 0) begin
                    $display("%0t: unexpected result owner=%0d status=%0d last=%0b",
                             $time, m_axis_tdata[3:0], m_axis_tdata[5:4], m_axis_tlast);
                    err_count++;
                end else begin
                    e = owner_q.pop_front();
                    if (e.status == cbop_pkg::STATUS_DEFERRED) deferred_seen++;
                    if (e.status == cbop_pkg::STATUS_RANGE) range_seen++;
                    if (m_axis_tdata[3:0] !== e.owner) begin
                        $display("%0t: owner expected %0d actual %0d",
                                 $time, e.owner, m_axis_tdata[3:0]);
                        err_count++;
                    end
                    if (m_axis_tdata[5:4] !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, m_axis_tdata[5:4]);
                        err_count++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $display("%0t: batch end expected %0b actual %0b",
                                 $time, e.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
        end
    end

    initial begin
        #5ms;
        $display("tb_capped_bucket_owner_partitioner: done, errors");
        $finish;
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= cbop_pkg::REG_PARTS;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        parts_reg     = 5'd2;
        children_reg  = 9'd256;
        bucket_reg    = 48'd1;
        deferred_cnt  = 0;
        placed_cnt    = 0;
        cap_latched   = 0;
        err_count     = 0;
        req_count     = 0;
        res_count     = 0;
        deferred_seen = 0;
        range_seen    = 0;
        calm          = 1'b0;
        foreach (part_load[i]) part_load[i] = 0;
        foreach (owner_tbl[i]) owner_tbl[i] = 4'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_placement();
        test_directed_lookups();
        test_lookups(90, 9'd256, 48'd1);
        test_lookups(90, 9'd256, 48'd1000);
        calm = 1'b1;
        test_lookups(80, 9'd511, 48'h0100_0000);
        calm = 1'b0;
        test_lookups(60, 9'd1, 48'd37);
        test_lookups(50, 9'd0, 48'd3);
        test_lookups(60, 9'd100, 48'd4096);
        test_lookups(40, 9'd256, OFF_MAX);
        test_lookups(40, 9'd256, 48'd0);
        test_lookups(90, 9'd200, 48'($urandom_range(1, 1 << 30)));
        drain(LOOK_SETTLE);
        if (owner_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, owner_q.size());
            err_count++;
        end

        $display("covered %0d requests, %0d results: one placement phase of %0d children",
                 req_count, res_count, FANOUT);
        $display("with rebalancing, then lookups over varied bucket sizes (%0d deferred, %0d range)",
                 deferred_seen, range_seen);
        if (err_count == 0)
            $display("tb_capped_bucket_owner_partitioner: done, clean");
        else
            $display("tb_capped_bucket_owner_partitioner: done, errors");
        $finish;
    end

endmodule
